// ===== rtl/srmp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the sensor record message parser.
// No dependencies.
package srmp_pkg;

  localparam int MAX_RECORDS = 5;
  localparam int ROM_DIGITS  = 16;
  localparam int VALUE_CHARS = 8;

  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_AW    = 2;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;

  localparam int KW_LEN = 6;
  localparam logic [7:0] KEYWORD [KW_LEN] = '{8'h73, 8'h65, 8'h6E, 8'h73, 8'h6F, 8'h72};

  typedef enum logic [1:0] {
    KIND_RECORD = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2,
    KIND_TEXT   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_LEAD     = 4'd0,
    ST_TEXT     = 4'd1,
    ST_PRE_KW   = 4'd2,
    ST_KW       = 4'd3,
    ST_PRE_ROM  = 4'd4,
    ST_ROM      = 4'd5,
    ST_POST_ROM = 4'd6,
    ST_PRE_VAL  = 4'd7,
    ST_VAL      = 4'd8,
    ST_POST_VAL = 4'd9,
    ST_DONE     = 4'd10
  } parse_state_t;

  // One entry of the event queue: what a single byte caused.
  typedef struct packed {
    logic        rec_valid;
    logic        stat_valid;
    kind_t       stat_kind;
    logic [2:0]  record_index;
    logic [63:0] rom_code;
    logic        negative;
    logic [26:0] magnitude;
    logic [2:0]  fraction_digits;
  } event_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_NL);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

endpackage

// ===== rtl/sensor_record_message_parser_top.sv =====
`timescale 1ns / 1ps
// Sensor record message parser, top level. Uses srmp_pkg, srmp_front,
// srmp_evq and srmp_back.
// A result word passes through the event queue and then the output register.
// Throughput: one byte per cycle unless the queue is full; a byte yielding
// a record and a status makes two words, absorbed by the four-entry queue.
// Reset (rst, synchronous) returns the parser to the start of a message and
// empties the queue and output register.
module sensor_record_message_parser_top import srmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [2:0]  record_index,
  output logic [63:0] rom_code,
  output logic        negative,
  output logic [26:0] magnitude,
  output logic [2:0]  fraction_digits,
  output logic        last
);

  logic   take, push, pop, not_empty, not_full;
  event_t wr_ev, rd_ev;

  assign in_ready = not_full;
  assign take     = in_valid && in_ready;

  srmp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .char_byte      (char_byte),
    .end_of_message (end_of_message),
    .push           (push),
    .ev             (wr_ev)
  );

  srmp_evq u_evq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_ev     (wr_ev),
    .pop       (pop),
    .rd_ev     (rd_ev),
    .not_empty (not_empty),
    .not_full  (not_full)
  );

  srmp_back u_back (
    .clk             (clk),
    .rst             (rst),
    .rd_ev           (rd_ev),
    .not_empty       (not_empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .record_index    (record_index),
    .rom_code        (rom_code),
    .negative        (negative),
    .magnitude       (magnitude),
    .fraction_digits (fraction_digits),
    .last            (last)
  );

endmodule

// ===== rtl/srmp_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts message bytes, runs the grammar state machine and
// pushes one event per byte that yields results. Depends on srmp_pkg.
module srmp_front import srmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  char_byte,
  input  logic        end_of_message,
  output logic        push,
  output event_t      ev
);

  parse_state_t st, st_next;
  logic [4:0]   tc, tc_next;
  logic [63:0]  rom, rom_next;
  logic [26:0]  vd, vd_next;
  logic         minus_f, minus_next;
  logic         dot_f, dot_next;
  logic [2:0]   frac, frac_next;
  logic [2:0]   rc, rc_next;
  logic         failed, failed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ST_LEAD;
      tc      <= '0;
      rom     <= '0;
      vd      <= '0;
      minus_f <= 1'b0;
      dot_f   <= 1'b0;
      frac    <= '0;
      rc      <= '0;
      failed  <= 1'b0;
    end else if (take) begin
      st      <= st_next;
      tc      <= tc_next;
      rom     <= rom_next;
      vd      <= vd_next;
      minus_f <= minus_next;
      dot_f   <= dot_next;
      frac    <= frac_next;
      rc      <= rc_next;
      failed  <= failed_next;
    end
  end

  always_comb begin
    logic       sp;
    logic       do_kw, do_rom, do_val, do_post;
    logic       used, val_fail;
    logic [3:0] hexv;
    logic       hex_ok;
    sp      = is_space(char_byte);
    do_kw   = 1'b0;
    do_rom  = 1'b0;
    do_val  = 1'b0;
    do_post = 1'b0;
    used    = 1'b0;
    val_fail = 1'b0;
    hexv    = '0;
    hex_ok  = 1'b0;

    st_next     = st;
    tc_next     = tc;
    rom_next    = rom;
    vd_next     = vd;
    minus_next  = minus_f;
    dot_next    = dot_f;
    frac_next   = frac;
    rc_next     = rc;
    failed_next = failed;

    ev   = '0;
    push = 1'b0;

    if (!failed) begin
      unique case (st)
        ST_LEAD: begin
          if (!sp) begin
            if (char_byte == CH_LBRACE) begin
              tc_next    = '0;
              rom_next   = '0;
              vd_next    = '0;
              minus_next = 1'b0;
              dot_next   = 1'b0;
              frac_next  = '0;
              st_next    = ST_PRE_KW;
            end else begin
              st_next = ST_TEXT;
            end
          end
        end
        ST_TEXT: ;
        ST_PRE_KW:   do_kw = !sp;
        ST_KW:       do_kw = 1'b1;
        ST_PRE_ROM:  do_rom = !sp;
        ST_ROM:      do_rom = 1'b1;
        ST_POST_ROM: begin
          if (!sp) begin
            if (char_byte == CH_COLON) begin
              tc_next = '0;
              st_next = ST_PRE_VAL;
            end else begin
              failed_next = 1'b1;
            end
          end
        end
        ST_PRE_VAL:  do_val = !sp;
        ST_VAL:      do_val = 1'b1;
        ST_POST_VAL: do_post = 1'b1;
        default:     failed_next = 1'b1;
      endcase
    end

    if (do_kw) begin
      if (tc < 5'(KW_LEN) && char_byte == KEYWORD[tc[2:0]]) begin
        tc_next = tc + 5'd1;
        st_next = ST_KW;
        if (tc_next >= 5'(KW_LEN)) begin
          tc_next = '0;
          st_next = ST_PRE_ROM;
        end
      end else begin
        failed_next = 1'b1;
      end
    end

    if (do_rom) begin
      if (is_digit(char_byte)) begin
        hexv   = char_byte[3:0];
        hex_ok = 1'b1;
      end else if (char_byte >= 8'h61 && char_byte <= 8'h66) begin
        hexv   = 4'(char_byte - 8'h57);
        hex_ok = 1'b1;
      end
      if (hex_ok) begin
        rom_next = {rom[59:0], hexv};
        tc_next  = tc + 5'd1;
        st_next  = ST_ROM;
        if (tc_next >= 5'(ROM_DIGITS)) begin
          tc_next = '0;
          st_next = ST_POST_ROM;
        end
      end else begin
        failed_next = 1'b1;
      end
    end

    if (do_val) begin
      used = 1'b1;
      if (tc == 5'd0 && char_byte == CH_MINUS) begin
        minus_next = 1'b1;
      end else if (is_digit(char_byte)) begin
        // times ten as two shifts
        vd_next = (vd << 3) + (vd << 1) + 27'(char_byte[3:0]);
        if (dot_f) frac_next = frac + 3'd1;
      end else if (char_byte == CH_DOT) begin
        if (dot_f) begin
          failed_next = 1'b1;
          val_fail    = 1'b1;
        end else begin
          dot_next = 1'b1;
        end
      end else begin
        used = 1'b0;
      end
      if (!val_fail) begin
        // record fields are taken before a comma clears them
        ev.rec_valid       = !used || (tc + 5'd1 >= 5'(VALUE_CHARS));
        ev.record_index    = rc;
        ev.rom_code        = rom;
        ev.negative        = minus_next;
        ev.magnitude       = vd_next;
        ev.fraction_digits = frac_next;
        if (used) begin
          tc_next = tc + 5'd1;
          st_next = ST_VAL;
          if (tc_next >= 5'(VALUE_CHARS)) begin
            tc_next = '0;
            st_next = ST_POST_VAL;
          end
        end else begin
          tc_next = '0;
          do_post = 1'b1;
        end
      end
    end

    if (do_post) begin
      st_next = ST_POST_VAL;
      if (!sp) begin
        if (char_byte == CH_COMMA) begin
          if ({1'b0, rc} + 4'd1 >= 4'(MAX_RECORDS)) begin
            failed_next = 1'b1;
          end else begin
            rc_next    = rc + 3'd1;
            tc_next    = '0;
            rom_next   = '0;
            vd_next    = '0;
            minus_next = 1'b0;
            dot_next   = 1'b0;
            frac_next  = '0;
            st_next    = ST_PRE_KW;
          end
        end else if (char_byte == CH_RBRACE) begin
          st_next = ST_DONE;
        end else begin
          failed_next = 1'b1;
        end
      end
    end

    if (end_of_message) begin
      ev.stat_valid = 1'b1;
      if (failed_next)                                ev.stat_kind = KIND_REJECT;
      else if (st_next == ST_TEXT || st_next == ST_LEAD) ev.stat_kind = KIND_TEXT;
      else if (st_next == ST_DONE)                    ev.stat_kind = KIND_ACCEPT;
      else                                            ev.stat_kind = KIND_REJECT;
      st_next     = ST_LEAD;
      tc_next     = '0;
      rom_next    = '0;
      vd_next     = '0;
      minus_next  = 1'b0;
      dot_next    = 1'b0;
      frac_next   = '0;
      rc_next     = '0;
      failed_next = 1'b0;
    end

    push = take && (ev.rec_valid || ev.stat_valid);
  end

endmodule

// ===== rtl/srmp_evq.sv =====
`timescale 1ns / 1ps
// Short event queue between the parser front end and the output stage.
// Depends on srmp_pkg.
module srmp_evq import srmp_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t wr_ev,
  input  logic   pop,
  output event_t rd_ev,
  output logic   not_empty,
  output logic   not_full
);

  event_t               mem [EVQ_DEPTH];
  logic [EVQ_AW-1:0]    wr_ptr, rd_ptr;
  logic [EVQ_AW:0]      count;

  assign not_empty = (count != '0);
  assign not_full  = (count != (EVQ_AW+1)'(EVQ_DEPTH));
  assign rd_ev     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + EVQ_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + EVQ_AW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (EVQ_AW+1)'(1);
        2'b01:   count <= count - (EVQ_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/srmp_back.sv =====
`timescale 1ns / 1ps
// Output stage: pops events and sends one result word per cycle when not
// stalled, a record then a status when a byte caused both. Uses srmp_pkg.
module srmp_back import srmp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  event_t      rd_ev,
  input  logic        not_empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [2:0]  record_index,
  output logic [63:0] rom_code,
  output logic        negative,
  output logic [26:0] magnitude,
  output logic [2:0]  fraction_digits,
  output logic        last
);

  logic  pend_stat;
  kind_t pend_kind;
  logic  can_load;

  assign can_load = !out_valid || out_ready;
  assign pop      = can_load && !pend_stat && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_stat <= 1'b0;
    end else if (can_load) begin
      if (pend_stat) begin
        out_valid <= 1'b1;
        pend_stat <= 1'b0;
      end else if (not_empty) begin
        out_valid <= 1'b1;
        pend_stat <= rd_ev.rec_valid && rd_ev.stat_valid;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (can_load) begin
      if (pend_stat || (not_empty && !rd_ev.rec_valid)) begin
        kind            <= pend_stat ? pend_kind : rd_ev.stat_kind;
        record_index    <= '0;
        rom_code        <= '0;
        negative        <= 1'b0;
        magnitude       <= '0;
        fraction_digits <= '0;
        last            <= 1'b1;
      end else if (not_empty) begin
        kind            <= KIND_RECORD;
        record_index    <= rd_ev.record_index;
        rom_code        <= rd_ev.rom_code;
        negative        <= rd_ev.negative;
        magnitude       <= rd_ev.magnitude;
        fraction_digits <= rd_ev.fraction_digits;
        last            <= !rd_ev.stat_valid;
        pend_kind       <= rd_ev.stat_kind;
      end
    end
  end

endmodule
